// File: rtl/nfpes_pkg.sv
// Shared types and constants for the NOR flash program/erase sequencer.
// No dependencies; used by every module under rtl.
package nfpes_pkg;

  // input item codes
  localparam logic [2:0] MODE_PROGRAM = 3'd0;
  localparam logic [2:0] MODE_ERASE   = 3'd1;
  localparam logic [2:0] MODE_READ    = 3'd2;
  localparam logic [2:0] MODE_RDATA   = 3'd3;
  localparam logic [2:0] MODE_TICK    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_ACTIVE_WORDS = 2'd0;
  localparam logic [1:0] REG_PROG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_ERASE_TIMEOUT = 2'd2;

  localparam int ACTIVE_W   = 23;
  localparam int CFG_W      = 23;
  localparam int PROG_TO_W  = 16;
  localparam int TICKS_W    = 18;
  localparam int DATA_W     = 16;
  localparam int STEP_W     = 3;
  localparam int JOBQ_DEPTH = 2;

  localparam logic [ACTIVE_W-1:0]  ACTIVE_RST   = 23'd4194304;
  localparam logic [PROG_TO_W-1:0] PROG_TO_RST  = 16'd5;
  localparam logic [TICKS_W-1:0]   ERASE_TO_RST = 18'd180000;

  // JEDEC command cycles
  localparam logic [11:0] UNLOCK_ADDR1 = 12'h555;
  localparam logic [11:0] UNLOCK_ADDR2 = 12'h2AA;
  localparam logic [DATA_W-1:0] CMD_UNLOCK1 = 16'h00AA;
  localparam logic [DATA_W-1:0] CMD_UNLOCK2 = 16'h0055;
  localparam logic [DATA_W-1:0] CMD_ERASE   = 16'h0080;
  localparam logic [DATA_W-1:0] CMD_CHIP    = 16'h0010;
  localparam logic [DATA_W-1:0] CMD_PROGRAM = 16'h00A0;
  localparam logic [DATA_W-1:0] ERASED_WORD = 16'hFFFF;

  localparam int DQ6_BIT = 6;
  localparam int DQ5_BIT = 5;

  typedef enum logic [1:0] {
    OUT_WRITE = 2'd0,
    OUT_READ  = 2'd1,
    OUT_DONE  = 2'd2,
    OUT_RDATA = 2'd3
  } out_kind_t;

  typedef enum logic [2:0] {
    JOB_FINISH  = 3'd0,
    JOB_PROGRAM = 3'd1,
    JOB_ERASE   = 3'd2,
    JOB_READ    = 3'd3,
    JOB_PLAIN   = 3'd4
  } job_kind_t;

  typedef struct packed {
    job_kind_t kind;
    logic      ok;
  } job_ctl_t;

endpackage

// File: rtl/nfpes_front.sv
// Front end: config registers, operation phase tracking and job classification.
// Depends on nfpes_pkg; feeds jobs to nfpes_jobq.
module nfpes_front #(
  parameter int ADDR_BITS = 22,
  parameter int CFG_W = 23
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_mode,
  input  logic [ADDR_BITS-1:0] in_address,
  input  logic [15:0]          in_write_data,
  input  logic [15:0]          in_read_data,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic                 job_valid,
  input  logic                 job_ready,
  output nfpes_pkg::job_ctl_t  job_ctl,
  output logic [ADDR_BITS-1:0] job_addr,
  output logic [15:0]          job_data
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_PLAIN, PH_FIRST, PH_POLL, PH_FINAL, PH_VERIFY
  } phase_t;

  localparam int CMP_W = (ADDR_BITS > nfpes_pkg::ACTIVE_W) ? ADDR_BITS : nfpes_pkg::ACTIVE_W;

  phase_t                       phase_r, phase_nxt;
  logic [ADDR_BITS-1:0]         target_r, target_nxt;
  logic [15:0]                  expect_r, expect_nxt;
  logic [15:0]                  prev_r, prev_nxt;
  logic [nfpes_pkg::TICKS_W-1:0] ticks_r, ticks_nxt;
  logic                         late_r, late_nxt;
  logic [nfpes_pkg::ACTIVE_W-1:0] active_words_r;
  logic [nfpes_pkg::PROG_TO_W-1:0] prog_to_r;
  logic [nfpes_pkg::TICKS_W-1:0] erase_to_r;

  logic accept;
  logic toggled;
  logic dq5;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;
  assign toggled  = prev_r[nfpes_pkg::DQ6_BIT] ^ in_read_data[nfpes_pkg::DQ6_BIT];
  assign dq5      = in_read_data[nfpes_pkg::DQ5_BIT];

  always_comb begin
    phase_nxt  = phase_r;
    target_nxt = target_r;
    expect_nxt = expect_r;
    prev_nxt   = prev_r;
    ticks_nxt  = ticks_r;
    late_nxt   = late_r;
    job_valid  = 1'b0;
    job_ctl    = '{kind: nfpes_pkg::JOB_FINISH, ok: 1'b0};
    job_addr   = target_r;
    job_data   = '0;
    if (accept) begin
      priority if (in_mode == nfpes_pkg::MODE_TICK) begin
        if (phase_r != PH_IDLE && phase_r != PH_PLAIN && ticks_r != '0) begin
          ticks_nxt = ticks_r - 1'b1;
          if (ticks_r == nfpes_pkg::TICKS_W'(1)) late_nxt = 1'b1;
        end
      end else if (phase_r == PH_IDLE) begin
        if (in_mode == nfpes_pkg::MODE_PROGRAM) begin
          job_valid = 1'b1;
          if (CMP_W'(in_address) >= CMP_W'(active_words_r)) begin
            job_ctl.ok = 1'b0;
          end else if (in_write_data == nfpes_pkg::ERASED_WORD) begin
            job_ctl.ok = 1'b1;
          end else begin
            job_ctl.kind = nfpes_pkg::JOB_PROGRAM;
            job_addr     = in_address;
            job_data     = in_write_data;
            target_nxt   = in_address;
            expect_nxt   = in_write_data;
            ticks_nxt    = nfpes_pkg::TICKS_W'(prog_to_r);
            late_nxt     = (prog_to_r == '0);
            phase_nxt    = PH_FIRST;
          end
        end else if (in_mode == nfpes_pkg::MODE_ERASE) begin
          job_valid    = 1'b1;
          job_ctl.kind = nfpes_pkg::JOB_ERASE;
          job_addr     = '0;
          target_nxt   = '0;
          expect_nxt   = nfpes_pkg::ERASED_WORD;
          ticks_nxt    = erase_to_r;
          late_nxt     = (erase_to_r == '0);
          phase_nxt    = PH_FIRST;
        end else if (in_mode == nfpes_pkg::MODE_READ) begin
          job_valid    = 1'b1;
          job_ctl.kind = nfpes_pkg::JOB_READ;
          job_addr     = in_address;
          target_nxt   = in_address;
          phase_nxt    = PH_PLAIN;
        end
      end else if (in_mode == nfpes_pkg::MODE_RDATA) begin
        unique case (phase_r)
          PH_PLAIN: begin
            job_valid    = 1'b1;
            job_ctl.kind = nfpes_pkg::JOB_PLAIN;
            job_data     = in_read_data;
            phase_nxt    = PH_IDLE;
          end
          PH_FIRST: begin
            prev_nxt     = in_read_data;
            job_valid    = 1'b1;
            job_ctl.kind = nfpes_pkg::JOB_READ;
            phase_nxt    = PH_POLL;
          end
          PH_POLL: begin
            job_valid = 1'b1;
            if (!toggled) begin
              job_ctl.kind = nfpes_pkg::JOB_READ;
              phase_nxt    = PH_VERIFY;
            end else if (dq5) begin
              // device flagged a timeout: one more read to see if it settled
              prev_nxt     = in_read_data;
              job_ctl.kind = nfpes_pkg::JOB_READ;
              phase_nxt    = PH_FINAL;
            end else begin
              prev_nxt = in_read_data;
              if (late_r) begin
                phase_nxt = PH_IDLE;
              end else begin
                job_ctl.kind = nfpes_pkg::JOB_READ;
              end
            end
          end
          PH_FINAL: begin
            job_valid = 1'b1;
            if (!toggled) begin
              job_ctl.kind = nfpes_pkg::JOB_READ;
              phase_nxt    = PH_VERIFY;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_VERIFY: begin
            job_valid  = 1'b1;
            job_ctl.ok = (in_read_data == expect_r);
            phase_nxt  = PH_IDLE;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end else begin
        // requests while busy and other stray beats are dropped
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      target_r       <= '0;
      expect_r       <= '0;
      prev_r         <= '0;
      ticks_r        <= '0;
      late_r         <= 1'b0;
      active_words_r <= nfpes_pkg::ACTIVE_RST;
      prog_to_r      <= nfpes_pkg::PROG_TO_RST;
      erase_to_r     <= nfpes_pkg::ERASE_TO_RST;
    end else begin
      phase_r  <= phase_nxt;
      target_r <= target_nxt;
      expect_r <= expect_nxt;
      prev_r   <= prev_nxt;
      ticks_r  <= ticks_nxt;
      late_r   <= late_nxt;
      if (cfg_valid) begin
        if (cfg_index == nfpes_pkg::REG_ACTIVE_WORDS)
          active_words_r <= cfg_wdata[nfpes_pkg::ACTIVE_W-1:0];
        if (cfg_index == nfpes_pkg::REG_PROG_TIMEOUT) prog_to_r <= cfg_wdata[15:0];
        if (cfg_index == nfpes_pkg::REG_ERASE_TIMEOUT) erase_to_r <= cfg_wdata[17:0];
      end
    end
  end

endmodule

// File: rtl/nfpes_jobq.sv
// Short job queue between the classifying front end and the bus-cycle back end.
// Depends on nfpes_pkg for its depth.
module nfpes_jobq #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int DEPTH = nfpes_pkg::JOBQ_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] count_r;
  logic          push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + PW'(1);
      if (pop)  rptr_r <= rptr_r + PW'(1);
      if (push && !pop)      count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

endmodule

// File: rtl/nfpes_back.sv
// Back end: expands queued jobs into bus-cycle and status beats, one per cycle while out_ready is high.
// Depends on nfpes_pkg; drives the registered result channel.
module nfpes_back #(
  parameter int ADDR_BITS = 22
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  nfpes_pkg::job_ctl_t  job_ctl,
  input  logic [ADDR_BITS-1:0] job_addr,
  input  logic [15:0]          job_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic [ADDR_BITS-1:0] out_bus_address,
  output logic [15:0]          out_bus_data,
  output logic                 out_success,
  output logic                 out_last
);

  localparam logic [ADDR_BITS-1:0] A_UNL1 = ADDR_BITS'(nfpes_pkg::UNLOCK_ADDR1);
  localparam logic [ADDR_BITS-1:0] A_UNL2 = ADDR_BITS'(nfpes_pkg::UNLOCK_ADDR2);

  logic                         cur_valid_r;
  nfpes_pkg::job_ctl_t          cur_ctl_r;
  logic [ADDR_BITS-1:0]         cur_addr_r;
  logic [15:0]                  cur_data_r;
  logic [nfpes_pkg::STEP_W-1:0] step_r;

  logic                 valid_r, success_r, last_r;
  nfpes_pkg::out_kind_t kind_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [15:0]          data_r;

  nfpes_pkg::out_kind_t b_kind;
  logic [ADDR_BITS-1:0] b_addr;
  logic [15:0]          b_data;
  logic                 b_ok, b_last;
  logic                 load, job_done;

  assign load      = cur_valid_r && (!valid_r || out_ready);
  assign job_done  = load && b_last;
  assign job_ready = !cur_valid_r || job_done;

  always_comb begin
    b_kind = nfpes_pkg::OUT_WRITE;
    b_addr = A_UNL1;
    b_data = nfpes_pkg::CMD_UNLOCK1;
    b_ok   = 1'b0;
    b_last = 1'b0;
    unique case (cur_ctl_r.kind)
      nfpes_pkg::JOB_PROGRAM: begin
        unique case (step_r)
          3'd0: ;
          3'd1: begin b_addr = A_UNL2; b_data = nfpes_pkg::CMD_UNLOCK2; end
          3'd2: b_data = nfpes_pkg::CMD_PROGRAM;
          3'd3: begin b_addr = cur_addr_r; b_data = cur_data_r; end
          default: begin
            b_kind = nfpes_pkg::OUT_READ;
            b_addr = cur_addr_r;
            b_data = '0;
            b_last = 1'b1;
          end
        endcase
      end
      nfpes_pkg::JOB_ERASE: begin
        // unlock, 80, unlock, 10, then the first status read at word 0
        unique case (step_r)
          3'd0, 3'd3: ;
          3'd1, 3'd4: begin b_addr = A_UNL2; b_data = nfpes_pkg::CMD_UNLOCK2; end
          3'd2: b_data = nfpes_pkg::CMD_ERASE;
          3'd5: b_data = nfpes_pkg::CMD_CHIP;
          default: begin
            b_kind = nfpes_pkg::OUT_READ;
            b_addr = cur_addr_r;
            b_data = '0;
            b_last = 1'b1;
          end
        endcase
      end
      nfpes_pkg::JOB_READ: begin
        b_kind = nfpes_pkg::OUT_READ;
        b_addr = cur_addr_r;
        b_data = '0;
        b_last = 1'b1;
      end
      nfpes_pkg::JOB_PLAIN: begin
        b_kind = nfpes_pkg::OUT_RDATA;
        b_addr = cur_addr_r;
        b_data = cur_data_r;
        b_last = 1'b1;
      end
      default: begin
        b_kind = nfpes_pkg::OUT_DONE;
        b_addr = '0;
        b_data = '0;
        b_ok   = cur_ctl_r.ok;
        b_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= '0;
      valid_r     <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        cur_valid_r <= 1'b1;
        step_r      <= '0;
      end else if (job_done) begin
        cur_valid_r <= 1'b0;
      end else if (load) begin
        step_r <= step_r + 1'b1;
      end
      if (load)           valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      cur_ctl_r  <= job_ctl;
      cur_addr_r <= job_addr;
      cur_data_r <= job_data;
    end
    if (load) begin
      kind_r    <= b_kind;
      addr_r    <= b_addr;
      data_r    <= b_data;
      success_r <= b_ok;
      last_r    <= b_last;
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = kind_r;
  assign out_bus_address = addr_r;
  assign out_bus_data    = data_r;
  assign out_success     = success_r;
  assign out_last        = last_r;

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r == nfpes_pkg::OUT_DONE) |-> last_r)
    else $error("status beat without last");
  a_ok_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && success_r) |-> (kind_r == nfpes_pkg::OUT_DONE))
    else $error("success set on a non-status beat");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (step_r <= nfpes_pkg::STEP_W'(6)))
    else $error("job step past end of erase run");
  a_done_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    job_done |=> (valid_r && last_r))
    else $error("job end did not present a last beat");
`endif

endmodule

// File: rtl/nor_flash_program_erase_sequencer.sv
// Top level of the NOR flash program/erase sequencer with toggle-bit polling.
// Depends on nfpes_pkg, nfpes_front, nfpes_jobq and nfpes_back.
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | mode, address, write_data, read_data
//  out_    | output    | out_valid / out_ready | kind, bus_address, bus_data, success, last
//  cfg_    | input     | cfg_valid / cfg_ready | index, wdata (always ready)
//
// An item is taken every cycle while the two-entry job queue has room; the front end
// classifies it and updates the polling state at the accepting edge, and its first
// beat passes through the queue and the back end's job register to the output register.
// While out_ready is high the back end emits one result beat per cycle: none for
// ignored items, 1 for reads, polls and status, 5 for a program, 7 for a chip erase.
// While out_ready is low, the output register, the job in the back end and two
// queued jobs hold, then in_ready drops.
// Reset is synchronous, active low: phase idle, queue empty, registers at defaults.
module nor_flash_program_erase_sequencer #(
  parameter int ADDR_BITS = 22,
  localparam int CFG_W = nfpes_pkg::CFG_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_mode,
  input  logic [ADDR_BITS-1:0] in_address,
  input  logic [15:0]          in_write_data,
  input  logic [15:0]          in_read_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic [ADDR_BITS-1:0] out_bus_address,
  output logic [15:0]          out_bus_data,
  output logic                 out_success,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CTL_W = $bits(nfpes_pkg::job_ctl_t);
  localparam int JOB_W = CTL_W + ADDR_BITS + 16;

  logic                 fq_valid, fq_ready, qb_valid, qb_ready;
  nfpes_pkg::job_ctl_t  f_ctl, b_ctl;
  logic [ADDR_BITS-1:0] f_addr, b_addr;
  logic [15:0]          f_data, b_data;
  logic [JOB_W-1:0]     q_in, q_out;

  assign cfg_ready = 1'b1;

  nfpes_front #(.ADDR_BITS(ADDR_BITS), .CFG_W(CFG_W)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_address(in_address), .in_write_data(in_write_data),
    .in_read_data(in_read_data),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .job_valid(fq_valid), .job_ready(fq_ready), .job_ctl(f_ctl),
    .job_addr(f_addr), .job_data(f_data)
  );

  assign q_in = {f_ctl, f_addr, f_data};

  nfpes_jobq #(.W(JOB_W)) u_jobq (
    .clk(clk), .rst_n(rst_n),
    .push_valid(fq_valid), .push_ready(fq_ready), .push_data(q_in),
    .pop_valid(qb_valid), .pop_ready(qb_ready), .pop_data(q_out)
  );

  assign b_ctl  = nfpes_pkg::job_ctl_t'(q_out[JOB_W-1 -: CTL_W]);
  assign b_addr = q_out[ADDR_BITS+15:16];
  assign b_data = q_out[15:0];

  nfpes_back #(.ADDR_BITS(ADDR_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(qb_valid), .job_ready(qb_ready), .job_ctl(b_ctl),
    .job_addr(b_addr), .job_data(b_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_bus_address(out_bus_address), .out_bus_data(out_bus_data),
    .out_success(out_success), .out_last(out_last)
  );

endmodule
